### rtl/stce_pkg.sv
// ----------------------------------------------------------------------------
// stce_pkg
// Types, codes and defaults shared by the connection engine modules.
// ----------------------------------------------------------------------------
package stce_pkg;

  localparam int SEGMENT_BYTES_DEF      = 1024;
  localparam int PACKETS_PER_WINDOW_DEF = 8;
  localparam int FQ_DEPTH               = 2;
  localparam int OQ_DEPTH               = 4;

  // request types on the input channel
  localparam logic [1:0] RT_START   = 2'd0;
  localparam logic [1:0] RT_SEGMENT = 2'd1;
  localparam logic [1:0] RT_TICK    = 2'd2;

  // segment flag bits
  localparam logic [3:0] F_NONE = 4'b0000;
  localparam logic [3:0] F_SYN  = 4'b0001;
  localparam logic [3:0] F_ACK  = 4'b0010;
  localparam logic [3:0] F_FIN  = 4'b0100;
  localparam logic [3:0] F_RST  = 4'b1000;
  localparam logic [3:0] F_SYNACK = 4'b0011;

  // result kinds
  localparam logic [2:0] K_SEG       = 3'd0;
  localparam logic [2:0] K_WRITE_END = 3'd1;
  localparam logic [2:0] K_RECV_END  = 3'd2;
  localparam logic [2:0] K_FINISHED  = 3'd3;
  localparam logic [2:0] K_ERROR     = 3'd4;

  // configuration register indexes
  localparam logic [2:0] R_LOCAL_PORT   = 3'd0;
  localparam logic [2:0] R_INITIAL_SEQ  = 3'd1;
  localparam logic [2:0] R_RESEND_LIMIT = 3'd2;
  localparam logic [2:0] R_CONNECT_WAIT = 3'd3;
  localparam logic [2:0] R_AUTO_FINISH  = 3'd4;

  typedef enum logic [1:0] {
    CL_START, CL_SEGMENT, CL_TICK, CL_NONE
  } req_class_t;

  typedef enum logic [2:0] {
    CS_IDLE, CS_WAIT_RESPONSE, CS_WAIT_ACK, CS_R_WAIT, CS_RECEIVE
  } conn_state_t;

  typedef enum logic [2:0] {
    E_IDLE, E_EXEC, E_ACK1, E_ACK2, E_WIN, E_SEG, E_FINISH, E_RECVEND
  } eng_state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  seg_flags;
    logic [31:0] seg_seq;
    logic [31:0] seg_ack;
    logic [31:0] peer_addr;
    logic [15:0] peer_port;
    logic [23:0] data_length;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  out_kind;
    logic [3:0]  out_flags;
    logic [31:0] out_seq;
    logic [31:0] out_ack;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] dst_addr;
    logic [23:0] payload_offset;
    logic [10:0] payload_length;
    logic        last;
  } out_item_t;

  typedef struct packed {
    req_class_t cls;
    in_item_t   item;
  } front_item_t;

  typedef struct packed {
    logic [15:0] local_port;
    logic [31:0] initial_sequence;
    logic [7:0]  resend_limit;
    logic [15:0] connect_wait_limit;
    logic        auto_finish;
  } cfg_t;

endpackage

### rtl/simple_tcp_connection_engine_top.sv
// ----------------------------------------------------------------------------
// simple_tcp_connection_engine_top
// Simplified TCP endpoint: handshake, windowed send, delayed ACK, timers.
// ----------------------------------------------------------------------------
// Usage:
//   Requests (start send, received segment, tick) enter through push/full.
//   Results (segment descriptors and events) leave through empty/pop; the
//   final result of one request carries last = 1.
//   Registers are written through wr_en/wr_index/wr_data while idle.
// Flow:
//   A request waits in the front queue, is taken by the engine and then
//   yields its results; an ACK adds an offset product step and a removal
//   step, and a window adds a setup step. The engine emits one result a
//   cycle while the result queue has room.
// Reset:
//   Synchronous rst empties both queues and returns the connection to idle
//   with all registers at their defaults.
// Stalls:
//   When pop stays low the four-entry result queue fills, the engine holds,
//   and the two-entry front queue raises full.
// ----------------------------------------------------------------------------
module simple_tcp_connection_engine_top import stce_pkg::*; #(
  parameter int SEGMENT_BYTES      = SEGMENT_BYTES_DEF,
  parameter int PACKETS_PER_WINDOW = PACKETS_PER_WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  in_item_t    request,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output out_item_t   result,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data
);

  cfg_t        cfg;
  logic        fr_valid;
  front_item_t fr_item;
  logic        fr_pop;
  logic        eng_wr;
  out_item_t   eng_item;
  logic        oq_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.local_port         <= '0;
      cfg.initial_sequence   <= '0;
      cfg.resend_limit       <= 8'd3;
      cfg.connect_wait_limit <= 16'd10;
      cfg.auto_finish        <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        R_LOCAL_PORT:   cfg.local_port         <= wr_data[15:0];
        R_INITIAL_SEQ:  cfg.initial_sequence   <= wr_data;
        R_RESEND_LIMIT: cfg.resend_limit       <= wr_data[7:0];
        R_CONNECT_WAIT: cfg.connect_wait_limit <= wr_data[15:0];
        R_AUTO_FINISH:  cfg.auto_finish        <= wr_data[0];
        default:        cfg.auto_finish        <= cfg.auto_finish;
      endcase
    end
  end

  stce_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .request  (request),
    .full     (full),
    .fr_valid (fr_valid),
    .fr_item  (fr_item),
    .fr_pop   (fr_pop)
  );

  stce_engine #(
    .SEGMENT_BYTES      (SEGMENT_BYTES),
    .PACKETS_PER_WINDOW (PACKETS_PER_WINDOW)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .fr_valid (fr_valid),
    .fr_item  (fr_item),
    .fr_pop   (fr_pop),
    .wr       (eng_wr),
    .wr_item  (eng_item),
    .oq_full  (oq_full)
  );

  stce_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .wr      (eng_wr),
    .wr_item (eng_item),
    .oq_full (oq_full),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

`ifndef NO_ASSERTIONS
  // engine only requests a result slot when the queue has room
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    eng_wr |-> !oq_full) else $error("result request while queue full");

  // engine takes a request only when the front holds one
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    fr_pop |-> fr_valid) else $error("front pop while empty");

  // reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty) else $error("results present after reset");
`endif

endmodule

### rtl/stce_front.sv
// ----------------------------------------------------------------------------
// stce_front
// Accepts requests, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module stce_front import stce_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  in_item_t    request,
  output logic        full,
  output logic        fr_valid,
  output front_item_t fr_item,
  input  logic        fr_pop
);

  localparam int PW = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
  localparam int CW = $clog2(FQ_DEPTH + 1);

  front_item_t     q [FQ_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;
  front_item_t     cls_item;

  assign full     = (count == CW'(FQ_DEPTH));
  assign fr_valid = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = fr_pop && fr_valid;
  assign fr_item  = q[rd_ptr];

  // classify the request type
  always_comb begin
    cls_item.item = request;
    case (request.req_type)
      RT_START:   cls_item.cls = CL_START;
      RT_SEGMENT: cls_item.cls = CL_SEGMENT;
      RT_TICK:    cls_item.cls = CL_TICK;
      default:    cls_item.cls = CL_NONE;
    endcase
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= cls_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(FQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(FQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/stce_outq.sv
// ----------------------------------------------------------------------------
// stce_outq
// Result queue between the engine and the result channel.
// ----------------------------------------------------------------------------
module stce_outq import stce_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr,
  input  out_item_t wr_item,
  output logic      oq_full,
  input  logic      pop,
  output logic      empty,
  output out_item_t result
);

  localparam int PW = $clog2(OQ_DEPTH);
  localparam int CW = $clog2(OQ_DEPTH + 1);

  out_item_t       q [OQ_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_wr;
  logic            do_pop;

  assign oq_full = (count == CW'(OQ_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !oq_full;
  assign do_pop  = pop && !empty;
  assign result  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr)  wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/stce_engine.sv
// ----------------------------------------------------------------------------
// stce_engine
// Connection state, timers and window sequencer; one result per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module stce_engine import stce_pkg::*; #(
  parameter int SEGMENT_BYTES      = SEGMENT_BYTES_DEF,
  parameter int PACKETS_PER_WINDOW = PACKETS_PER_WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        fr_valid,
  input  front_item_t fr_item,
  output logic        fr_pop,
  output logic        wr,
  output out_item_t   wr_item,
  input  logic        oq_full
);

  localparam int WIN_BYTES = SEGMENT_BYTES * PACKETS_PER_WINDOW;
  localparam int SBW       = $clog2(SEGMENT_BYTES + 1);
  localparam int WINW      = $clog2(WIN_BYTES + 1);
  localparam int PRW       = 31 + SBW;

  eng_state_t     st, st_next;
  front_item_t    cur;
  conn_state_t    conn;
  logic [31:0]    own_sequence;
  logic [31:0]    window_start_seq;
  logic [31:0]    remote_last_seq;
  logic [23:0]    bytes_remaining;
  logic [23:0]    bytes_acked;
  logic [7:0]     resend_count;
  logic [31:0]    wait_ticks;
  logic [31:0]    retry_ticks;
  logic [31:0]    retry_timeout;
  logic [1:0]     ack_delay_ticks;
  logic [31:0]    remote_addr;
  logic [15:0]    remote_port;
  logic           ack_pending;
  logic [31:0]    ack_diff;
  logic [PRW-1:0] prod;
  logic [WINW-1:0] left;
  logic [23:0]    offset;
  logic           fin_win;

  logic [3:0]     fl;
  logic           go;
  logic [31:0]    w_inc;
  logic [31:0]    r_inc;
  logic [1:0]     adt_inc;
  logic           tick_fail;
  logic           tick_win;
  logic           tick_ack;
  logic           idle_fin;
  logic           synack_ok;
  logic           win_err;
  logic [23:0]    rem;
  logic [23:0]    br_new;
  logic [WINW-1:0] win_c;
  logic [WINW-1:0] seg_len;
  logic [31:0]    len32;
  logic           seg_end;

  assign fl = cur.item.seg_flags;
  assign go = !oq_full;

  // tick counters, saturating
  assign w_inc   = (wait_ticks == '1) ? wait_ticks : wait_ticks + 1'b1;
  assign r_inc   = (retry_ticks == '1) ? retry_ticks : retry_ticks + 1'b1;
  assign adt_inc = (ack_delay_ticks == 2'd3) ? 2'd3 : ack_delay_ticks + 1'b1;
  assign tick_fail = (w_inc > {16'b0, cfg.connect_wait_limit}) &&
                     (conn == CS_WAIT_RESPONSE);
  assign tick_win  = !tick_fail && (r_inc == retry_timeout);
  assign tick_ack  = !tick_fail && !tick_win && ack_pending && (adt_inc >= 2'd2);

  assign idle_fin  = (conn == CS_IDLE) && (fl != F_SYN);
  assign synack_ok = (conn == CS_WAIT_RESPONSE) && (cur.item.seg_ack == own_sequence);
  assign win_err   = resend_count > cfg.resend_limit;

  // acknowledged byte removal, saturating at the bytes still owed
  assign rem    = (prod > PRW'(bytes_remaining)) ? bytes_remaining : prod[23:0];
  assign br_new = bytes_remaining - rem;

  // window size and per-segment length
  assign win_c   = (bytes_remaining < 24'(WIN_BYTES)) ? bytes_remaining[WINW-1:0]
                                                       : WINW'(WIN_BYTES);
  assign seg_end = (left <= WINW'(SEGMENT_BYTES));
  assign seg_len = seg_end ? left : WINW'(SEGMENT_BYTES);
  assign len32   = 32'(seg_len);

  // next state
  always_comb begin
    st_next = st;
    case (st)
      E_IDLE: begin
        if (fr_valid) st_next = E_EXEC;
      end
      E_EXEC: begin
        if (go) begin
          st_next = E_IDLE;
          case (cur.cls)
            CL_SEGMENT: begin
              if (!idle_fin) begin
                case (fl)
                  F_ACK:    if (conn == CS_WAIT_ACK) st_next = E_ACK1;
                  F_NONE:   if (conn == CS_R_WAIT) st_next = E_FINISH;
                  F_FIN:    st_next = E_RECVEND;
                  F_SYNACK: if (synack_ok) st_next = E_WIN;
                  default:  st_next = E_IDLE;
                endcase
              end
            end
            CL_TICK: if (tick_win) st_next = E_WIN;
            default: st_next = E_IDLE;
          endcase
        end
      end
      E_ACK1: st_next = E_ACK2;
      E_ACK2: begin
        if (go) begin
          if (br_new == '0) st_next = cfg.auto_finish ? E_FINISH : E_IDLE;
          else              st_next = E_WIN;
        end
      end
      E_WIN: begin
        if (go) st_next = (win_err || win_c == '0) ? E_IDLE : E_SEG;
      end
      E_SEG: begin
        if (go && seg_end) st_next = E_IDLE;
      end
      E_FINISH: if (go) st_next = E_IDLE;
      E_RECVEND: begin
        if (go) st_next = cfg.auto_finish ? E_FINISH : E_IDLE;
      end
      default: st_next = E_IDLE;
    endcase
  end

  // outputs: front pop and result request
  always_comb begin
    fr_pop  = (st == E_IDLE) && fr_valid;
    wr      = 1'b0;
    wr_item = '0;
    wr_item.src_port = cfg.local_port;
    wr_item.dst_port = remote_port;
    wr_item.dst_addr = remote_addr;
    case (st)
      E_EXEC: begin
        case (cur.cls)
          CL_START: begin
            wr = 1'b1;
            wr_item.out_flags = F_SYN;
            wr_item.out_seq   = own_sequence;
            wr_item.dst_port  = cur.item.peer_port;
            wr_item.dst_addr  = cur.item.peer_addr;
            wr_item.last      = 1'b1;
          end
          CL_SEGMENT: begin
            if (idle_fin) begin
              wr = 1'b1;
              wr_item = '0;
              wr_item.out_kind = K_FINISHED;
              wr_item.last     = 1'b1;
            end else begin
              case (fl)
                F_NONE: begin
                  if (conn == CS_R_WAIT) begin
                    wr = 1'b1;
                    wr_item.out_flags = F_RST;
                  end
                end
                F_FIN: begin
                  wr = 1'b1;
                  wr_item.out_flags = F_ACK;
                  wr_item.out_ack   = cur.item.seg_seq + 1'b1;
                end
                F_SYNACK: begin
                  if (synack_ok) begin
                    wr = 1'b1;
                    wr_item.out_flags = F_ACK;
                    wr_item.out_ack   = cur.item.seg_seq;
                    wr_item.last      = !win_err && (bytes_remaining == '0);
                  end
                end
                F_SYN: begin
                  wr = 1'b1;
                  wr_item.out_flags = F_SYNACK;
                  wr_item.out_seq   = own_sequence;
                  wr_item.out_ack   = cur.item.seg_seq;
                  wr_item.dst_port  = cur.item.peer_port;
                  wr_item.dst_addr  = cur.item.peer_addr;
                  wr_item.last      = 1'b1;
                end
                F_RST: begin
                  wr = 1'b1;
                  wr_item = '0;
                  wr_item.out_kind = K_ERROR;
                  wr_item.last     = 1'b1;
                end
                default: wr = 1'b0;
              endcase
            end
          end
          CL_TICK: begin
            if (tick_fail) begin
              wr = 1'b1;
              wr_item = '0;
              wr_item.out_kind = K_ERROR;
              wr_item.last     = 1'b1;
            end else if (tick_ack) begin
              wr = 1'b1;
              wr_item.out_flags = F_ACK;
              wr_item.out_ack   = remote_last_seq + 1'b1;
              wr_item.last      = 1'b1;
            end
          end
          default: wr = 1'b0;
        endcase
      end
      E_ACK2: begin
        if (br_new == '0) begin
          wr = 1'b1;
          wr_item = '0;
          wr_item.out_kind = K_WRITE_END;
          wr_item.last     = !cfg.auto_finish;
        end
      end
      E_WIN: begin
        if (win_err) begin
          wr = 1'b1;
          wr_item = '0;
          wr_item.out_kind = K_ERROR;
          wr_item.last     = 1'b1;
        end
      end
      E_SEG: begin
        wr = 1'b1;
        wr_item.out_flags      = (fin_win && seg_end) ? F_FIN : F_NONE;
        wr_item.out_seq        = own_sequence;
        wr_item.payload_offset = offset;
        wr_item.payload_length = len32[10:0];
        wr_item.last           = seg_end;
      end
      E_FINISH: begin
        wr = 1'b1;
        wr_item = '0;
        wr_item.out_kind = K_FINISHED;
        wr_item.last     = 1'b1;
      end
      E_RECVEND: begin
        wr = 1'b1;
        wr_item = '0;
        wr_item.out_kind = K_RECV_END;
        wr_item.last     = !cfg.auto_finish;
      end
      default: wr = 1'b0;
    endcase
    // hold the result back while the queue has no room
    if (!go) wr = 1'b0;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) st <= E_IDLE;
    else     st <= st_next;
  end

  // request latch and product step
  always_ff @(posedge clk) begin
    if (fr_pop) cur <= fr_item;
    if (st == E_ACK1) begin
      prod <= ack_diff[31] ? '0 : PRW'(ack_diff[30:0]) * PRW'(SEGMENT_BYTES);
    end
  end

  // connection state
  always_ff @(posedge clk) begin
    logic clr;
    clr = 1'b0;
    if (rst) begin
      clr = 1'b1;
    end else begin
      case (st)
        E_EXEC: begin
          if (go) begin
            case (cur.cls)
              CL_START: begin
                remote_addr     <= cur.item.peer_addr;
                remote_port     <= cur.item.peer_port;
                bytes_remaining <= cur.item.data_length;
                bytes_acked     <= '0;
                wait_ticks      <= '0;
                retry_timeout   <= '0;
                conn            <= CS_WAIT_RESPONSE;
              end
              CL_SEGMENT: begin
                if (idle_fin) begin
                  clr = 1'b1;
                end else begin
                  case (fl)
                    F_ACK: begin
                      if (conn == CS_R_WAIT) begin
                        conn <= CS_RECEIVE;
                      end else if (conn == CS_WAIT_ACK) begin
                        retry_ticks  <= '0;
                        resend_count <= '0;
                        ack_diff     <= cur.item.seg_ack - window_start_seq;
                      end
                    end
                    F_NONE: begin
                      if (conn != CS_R_WAIT) begin
                        ack_delay_ticks <= '0;
                        remote_last_seq <= cur.item.seg_seq;
                        ack_pending     <= 1'b1;
                      end
                    end
                    F_FIN: begin
                      ack_delay_ticks <= '0;
                      remote_last_seq <= '0;
                      ack_pending     <= 1'b0;
                    end
                    F_SYNACK: begin
                      if (conn == CS_WAIT_RESPONSE) begin
                        retry_timeout <= {wait_ticks[30:0], 1'b0};
                        if (synack_ok) own_sequence <= cur.item.seg_seq;
                      end
                    end
                    F_SYN: begin
                      remote_addr <= cur.item.peer_addr;
                      remote_port <= cur.item.peer_port;
                      conn        <= CS_R_WAIT;
                    end
                    F_RST: clr = 1'b1;
                    default: clr = 1'b0;
                  endcase
                end
              end
              CL_TICK: begin
                if (tick_fail) begin
                  clr = 1'b1;
                end else begin
                  wait_ticks  <= w_inc;
                  retry_ticks <= r_inc;
                  if (!tick_win && ack_pending) begin
                    if (tick_ack) begin
                      ack_delay_ticks <= '0;
                      remote_last_seq <= '0;
                      ack_pending     <= 1'b0;
                    end else begin
                      ack_delay_ticks <= adt_inc;
                    end
                  end
                end
              end
              default: clr = 1'b0;
            endcase
          end
        end
        E_ACK2: begin
          if (go) begin
            bytes_remaining <= br_new;
            bytes_acked     <= bytes_acked + rem;
            if (br_new == '0) retry_timeout <= '0;
          end
        end
        E_WIN: begin
          if (go) begin
            if (win_err) begin
              clr = 1'b1;
            end else begin
              if (resend_count != 8'hFF) resend_count <= resend_count + 1'b1;
              retry_ticks      <= '0;
              window_start_seq <= own_sequence;
              left             <= win_c;
              offset           <= bytes_acked;
              fin_win          <= (bytes_remaining <= 24'(WIN_BYTES));
              if (win_c == '0) conn <= CS_WAIT_ACK;
            end
          end
        end
        E_SEG: begin
          if (go) begin
            own_sequence <= own_sequence + 1'b1;
            left         <= left - seg_len;
            offset       <= offset + 24'(SEGMENT_BYTES);
            if (seg_end) conn <= CS_WAIT_ACK;
          end
        end
        E_FINISH: if (go) clr = 1'b1;
        default: clr = 1'b0;
      endcase
    end
    // return to idle: as after reset, but own_sequence takes the initial sequence register
    if (clr) begin
      conn             <= CS_IDLE;
      own_sequence     <= rst ? '0 : cfg.initial_sequence;
      window_start_seq <= '0;
      remote_last_seq  <= '0;
      bytes_remaining  <= '0;
      bytes_acked      <= '0;
      resend_count     <= '0;
      wait_ticks       <= '0;
      retry_ticks      <= '0;
      retry_timeout    <= '0;
      ack_delay_ticks  <= '0;
      remote_addr      <= '0;
      remote_port      <= '0;
      ack_pending      <= 1'b0;
    end
  end

endmodule

### dv/simple_tcp_connection_engine_checker.sv
// ----------------------------------------------------------------------------
// simple_tcp_connection_engine_checker
// Watches the request, result and register ports of the connection engine,
// predicts every result of each accepted request and compares them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module simple_tcp_connection_engine_checker import stce_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  in_item_t    request,
  input  logic        empty,
  input  logic        pop,
  input  out_item_t   result,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data,
  output int          errors,
  output int          pending,
  output logic [31:0] next_seq
);

  localparam int SEG_B = SEGMENT_BYTES_DEF;
  localparam int WIN_P = PACKETS_PER_WINDOW_DEF;

  // register copy
  logic [15:0] lport;
  logic [31:0] iseq;
  logic [7:0]  rlimit;
  logic [15:0] cwait;
  logic        afin;

  // connection copy
  conn_state_t st;
  logic [31:0] own_seq, win_seq, rlast, wticks, rticks, rtimeout, raddr;
  logic [23:0] brem, back;
  logic [7:0]  rcount;
  logic [1:0]  adelay;
  logic [15:0] rport;
  logic        ack_pend;

  out_item_t pending_results[$];
  int        step_n;

  assign pending  = pending_results.size();
  assign next_seq = own_seq;

  task automatic clear_conn();
    st = CS_IDLE; own_seq = iseq; win_seq = 0; rlast = 0; brem = 0; back = 0;
    rcount = 0; wticks = 0; rticks = 0; rtimeout = 0; adelay = 0;
    raddr = 0; rport = 0; ack_pend = 0;
  endtask

  task automatic put(logic [2:0] kind, logic [3:0] flg, logic [31:0] sq, logic [31:0] ak,
                     logic [15:0] sp, logic [15:0] dp, logic [31:0] da,
                     logic [23:0] off, logic [31:0] len);
    out_item_t r;
    if (step_n >= 16) return;
    r.out_kind = kind; r.out_flags = flg; r.out_seq = sq; r.out_ack = ak;
    r.src_port = sp; r.dst_port = dp; r.dst_addr = da;
    r.payload_offset = off; r.payload_length = len[10:0]; r.last = 1'b0;
    pending_results.push_back(r);
    step_n++;
  endtask

  task automatic seg(logic [3:0] flg, logic [31:0] sq, logic [31:0] ak,
                     logic [23:0] off, logic [31:0] len);
    put(K_SEG, flg, sq, ak, lport, rport, raddr, off, len);
  endtask

  task automatic emit_event(logic [2:0] kind);
    put(kind, F_NONE, 0, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic finish_conn();
    emit_event(K_FINISHED);
    clear_conn();
  endtask

  task automatic fail_conn();
    emit_event(K_ERROR);
    clear_conn();
  endtask

  task automatic send_ack();
    seg(F_ACK, 0, rlast + 1, 0, 0);
    adelay = 0; rlast = 0; ack_pend = 0;
  endtask

  // one window of up to WIN_P segments, FIN on the final segment of the last window
  task automatic send_window();
    logic [31:0] win, cnt, left, len;
    logic [3:0]  flg;
    if (rcount > rlimit) begin
      fail_conn();
      return;
    end
    if (rcount < 8'hFF) rcount++;
    rticks = 0;
    win_seq = own_seq;
    win = SEG_B * WIN_P;
    if (brem < win) win = brem;
    cnt = (win + SEG_B - 1) / SEG_B;
    left = win;
    for (int j = 0; j < cnt; j++) begin
      len = (left < SEG_B) ? left : SEG_B;
      flg = (brem <= SEG_B * WIN_P && j == cnt - 1) ? F_FIN : F_NONE;
      seg(flg, own_seq, 0, back + j * SEG_B, len);
      left -= len;
      own_seq++;
    end
    st = CS_WAIT_ACK;
  endtask

  task automatic on_ack(logic [31:0] ak);
    logic [31:0] d;
    logic [63:0] rem;
    if (st == CS_R_WAIT) begin
      st = CS_RECEIVE;
      return;
    end
    if (st != CS_WAIT_ACK) return;
    rticks = 0;
    rcount = 0;
    d = ak - win_seq;
    if (d < 32'h8000_0000) begin
      rem = 64'(d) * SEG_B;
      if (rem > brem) rem = brem;
      brem -= rem[23:0];
      back += rem[23:0];
    end
    if (brem == 0) begin
      rtimeout = 0;
      emit_event(K_WRITE_END);
      if (afin) finish_conn();
      return;
    end
    send_window();
  endtask

  task automatic on_segment(in_item_t it);
    if (st == CS_IDLE && it.seg_flags != F_SYN) begin
      finish_conn();
      return;
    end
    case (it.seg_flags)
      F_ACK: on_ack(it.seg_ack);
      F_NONE: begin
        if (st == CS_R_WAIT) begin
          seg(F_RST, 0, 0, 0, 0);
          finish_conn();
        end else begin
          adelay = 0; rlast = it.seg_seq; ack_pend = 1;
        end
      end
      F_FIN: begin
        rlast = it.seg_seq;
        send_ack();
        emit_event(K_RECV_END);
        if (afin) finish_conn();
      end
      F_SYNACK: begin
        if (st == CS_WAIT_RESPONSE) begin
          rtimeout = wticks * 2;
          if (it.seg_ack == own_seq) begin
            own_seq = it.seg_seq;
            seg(F_ACK, 0, it.seg_seq, 0, 0);
            send_window();
          end
        end
      end
      F_SYN: begin
        rport = it.peer_port;
        raddr = it.peer_addr;
        seg(F_SYNACK, own_seq, it.seg_seq, 0, 0);
        st = CS_R_WAIT;
      end
      F_RST: fail_conn();
      default: ;
    endcase
  endtask

  task automatic on_tick();
    if (wticks != 32'hFFFF_FFFF) wticks++;
    if (wticks > cwait && st == CS_WAIT_RESPONSE) begin
      fail_conn();
      return;
    end
    if (rticks != 32'hFFFF_FFFF) rticks++;
    if (rticks == rtimeout) begin
      send_window();
      return;
    end
    if (ack_pend) begin
      if (adelay < 3) adelay++;
      if (adelay >= 2) send_ack();
    end
  endtask

  task automatic predict_request(in_item_t it);
    int first;
    first = pending_results.size();
    step_n = 0;
    case (it.req_type)
      RT_START: begin
        raddr = it.peer_addr; rport = it.peer_port; brem = it.data_length;
        back = 0; wticks = 0; rtimeout = 0;
        seg(F_SYN, own_seq, 0, 0, 0);
        st = CS_WAIT_RESPONSE;
      end
      RT_SEGMENT: on_segment(it);
      RT_TICK: on_tick();
      default: ;
    endcase
    if (pending_results.size() > first)
      pending_results[pending_results.size() - 1].last = 1'b1;
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  task automatic check_result(out_item_t got);
    out_item_t w;
    if (pending_results.size() == 0) begin
      report("unexpected result kind", 32'(got.out_kind), 32'd0);
      return;
    end
    w = pending_results.pop_front();
    if (got.out_kind != w.out_kind) report("out_kind", got.out_kind, w.out_kind);
    if (got.out_flags != w.out_flags) report("out_flags", got.out_flags, w.out_flags);
    if (got.out_seq != w.out_seq) report("out_seq", got.out_seq, w.out_seq);
    if (got.out_ack != w.out_ack) report("out_ack", got.out_ack, w.out_ack);
    if (got.src_port != w.src_port) report("src_port", got.src_port, w.src_port);
    if (got.dst_port != w.dst_port) report("dst_port", got.dst_port, w.dst_port);
    if (got.dst_addr != w.dst_addr) report("dst_addr", got.dst_addr, w.dst_addr);
    if (got.payload_offset != w.payload_offset)
      report("payload_offset", got.payload_offset, w.payload_offset);
    if (got.payload_length != w.payload_length)
      report("payload_length", got.payload_length, w.payload_length);
    if (got.last != w.last) report("last", got.last, w.last);
  endtask

  // sample all channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      lport = 0; iseq = 0; rlimit = 3; cwait = 10; afin = 0;
      clear_conn();
      pending_results.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          R_LOCAL_PORT:   lport  = wr_data[15:0];
          R_INITIAL_SEQ:  iseq   = wr_data;
          R_RESEND_LIMIT: rlimit = wr_data[7:0];
          R_CONNECT_WAIT: cwait  = wr_data[15:0];
          R_AUTO_FINISH:  afin   = wr_data[0];
          default: ;
        endcase
      end
      if (push && !full) predict_request(request);
      if (pop && !empty) check_result(result);
    end
  end

endmodule

### dv/simple_tcp_connection_engine_top_tb.sv
// ----------------------------------------------------------------------------
// simple_tcp_connection_engine_top_tb
// Drives handshakes, windowed sends, received data and ticks into the
// connection engine under several register settings, with random gaps and
// stalls on both channels; the checker predicts and compares all results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module simple_tcp_connection_engine_top_tb;
  import stce_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 0;
  logic        rst = 1;
  logic        push = 0;
  in_item_t    request = '0;
  logic        full, empty;
  logic        pop = 0;
  out_item_t   result;
  logic        wr_en = 0;
  logic [2:0]  wr_index = '0;
  logic [31:0] wr_data = '0;
  int          errors, pending;
  logic [31:0] next_seq;

  int cycles = 0;
  int sent = 0;
  logic hold_req = 0;
  logic hold_seen = 0;
  int pop_gap = 0;

  simple_tcp_connection_engine_top DUT (
    .clk(clk), .rst(rst), .push(push), .request(request), .full(full),
    .empty(empty), .pop(pop), .result(result),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  simple_tcp_connection_engine_checker checker_i (
    .clk(clk), .rst(rst), .push(push), .full(full), .request(request),
    .empty(empty), .pop(pop), .result(result),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .errors(errors), .pending(pending), .next_seq(next_seq)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: random pop gaps, plus one long hold when asked
  always @(negedge clk) begin
    if (hold_req && !hold_seen) begin
      pop_gap = 300;
      hold_seen = 1'b1;
    end
    if (pop_gap > 0) begin
      pop <= 1'b0;
      pop_gap--;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 5) == 0)
        pop_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    end
  end

  function automatic in_item_t mk(logic [1:0] rt, logic [3:0] fl, logic [31:0] sq,
                                  logic [31:0] ak, logic [31:0] pa, logic [15:0] pp,
                                  logic [23:0] dl);
    in_item_t it;
    it.req_type = rt; it.seg_flags = fl; it.seg_seq = sq; it.seg_ack = ak;
    it.peer_addr = pa; it.peer_port = pp; it.data_length = dl;
    return it;
  endfunction

  // one request: optional gap, then hold push until accepted
  task automatic send_req(in_item_t it);
    int gap;
    gap = 0;
    if ($urandom_range(0, 3) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    request <= it;
    do @(posedge clk); while (full);
    @(negedge clk);
    sent++;
  endtask

  task automatic seg_req(logic [3:0] fl, logic [31:0] sq, logic [31:0] ak);
    send_req(mk(RT_SEGMENT, fl, sq, ak, $urandom, 16'($urandom), 24'($urandom)));
  endtask

  task automatic tick_req();
    send_req(mk(RT_TICK, 4'($urandom), $urandom, $urandom, $urandom, 16'($urandom),
                24'($urandom)));
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_regs(logic [15:0] lp, logic [31:0] is, logic [7:0] rl,
                          logic [15:0] cw, logic af);
    write_reg(R_LOCAL_PORT, 32'(lp));
    write_reg(R_INITIAL_SEQ, is);
    write_reg(R_RESEND_LIMIT, 32'(rl));
    write_reg(R_CONNECT_WAIT, 32'(cw));
    write_reg(R_AUTO_FINISH, 32'(af));
    write_reg(3'd7, $urandom);
  endtask

  function automatic logic [23:0] pick_len();
    if ($urandom_range(0, 9) == 0) return 24'($urandom);
    return 24'($urandom_range(0, 12000));
  endfunction

  // active open: start, SYN-ACK, then acks, ticks and retransmits
  task automatic active_send();
    int n;
    send_req(mk(RT_START, 4'($urandom), $urandom, $urandom, $urandom, 16'($urandom),
                pick_len()));
    n = $urandom_range(0, 3);
    repeat (n) tick_req();
    if ($urandom_range(0, 7) == 0) seg_req(F_SYNACK, $urandom, next_seq + 1);
    seg_req(F_SYNACK, $urandom, next_seq);
    repeat ($urandom_range(2, 6)) begin
      case ($urandom_range(0, 7))
        0, 1, 2: seg_req(F_ACK, $urandom, next_seq);
        3: seg_req(F_ACK, $urandom, next_seq - $urandom_range(1, 4));
        4: seg_req(F_ACK, $urandom, next_seq - $urandom_range(20, 100));
        5, 6: tick_req();
        default: seg_req(F_NONE, $urandom, $urandom);
      endcase
    end
  endtask

  // passive open: SYN, ACK, data with delayed ACKs, FIN
  task automatic passive_recv();
    seg_req(F_SYN, $urandom, $urandom);
    if ($urandom_range(0, 7) == 0) seg_req(F_NONE, $urandom, $urandom);
    seg_req(F_ACK, $urandom, $urandom);
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 1)) seg_req(F_NONE, $urandom, $urandom);
      else tick_req();
    end
    seg_req(F_FIN, $urandom, $urandom);
  endtask

  task automatic random_phase(int upto);
    while (sent < upto) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: active_send();
        5, 6, 7: passive_recv();
        default: send_req(mk(2'($urandom), 4'($urandom), $urandom, $urandom, $urandom,
                             16'($urandom), 24'($urandom)));
      endcase
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part under known settings
    set_regs(16'h1234, 32'h1000, 8'd1, 16'd2, 1'b0);
    send_req(mk(2'd3, 4'hF, '1, '1, '1, '1, '1));
    tick_req();
    seg_req(F_ACK, 0, 0);
    seg_req(4'hF, '1, '1);
    send_req(mk(RT_SEGMENT, F_SYN, '1, '1, '1, '1, '1));
    seg_req(F_NONE, 5, 0);
    seg_req(F_SYN, 32'h10, 0);
    seg_req(F_ACK, 0, 0);
    seg_req(F_NONE, 32'h44, 0);
    tick_req();
    tick_req();
    seg_req(4'h5, 0, 0);
    seg_req(F_FIN, '1, 0);
    send_req(mk(RT_START, 0, 0, 0, 32'hC0A8_0001, 16'd80, 24'd0));
    seg_req(F_SYNACK, 32'h500, next_seq);
    send_req(mk(RT_START, 0, 0, 0, 32'hC0A8_0001, 16'd80, 24'd9000));
    tick_req();
    seg_req(F_SYNACK, 32'h900, next_seq);
    seg_req(F_ACK, 0, next_seq - 8);
    tick_req();
    tick_req();
    tick_req();
    seg_req(F_RST, 0, 0);
    send_req(mk(RT_START, 0, 0, 0, 0, 0, 24'hFFFFFF));
    repeat (3) tick_req();
    drain();

    // random phases across register settings
    set_regs(16'hFFFF, 32'hFFFF_FFF0, 8'd0, 16'd0, 1'b1);
    random_phase(sent + 22);
    drain();

    set_regs(16'd0, 32'd0, 8'd255, 16'd65535, 1'b0);
    hold_req = 1'b1;
    random_phase(sent + 22);
    drain();

    set_regs(16'($urandom), $urandom, 8'd3, 16'd4, 1'b1);
    random_phase(sent + 22);
    drain();

    set_regs(16'($urandom), 32'hFFFF_FFFF, 8'($urandom_range(0, 5)),
             16'($urandom_range(1, 8)), 1'b0);
    random_phase(sent + 22);
    drain();

    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

### simple_tcp_connection_engine_top.f
rtl/stce_pkg.sv
rtl/stce_front.sv
rtl/stce_outq.sv
rtl/stce_engine.sv
rtl/simple_tcp_connection_engine_top.sv
dv/simple_tcp_connection_engine_checker.sv
dv/simple_tcp_connection_engine_top_tb.sv
